// ===== hdl/pmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmb_pkg
// shared types, widths and register codes of the peak meter ballistics block
// ----------------------------------------------------------------------------
package pmb_pkg;

	localparam int COLUMNS_DEF     = 32;
	localparam int CAP_CEILING_DEF = 65536;

	localparam int COL_W     = 5;
	localparam int LVL_W     = 18;
	localparam int VEL_W     = 20;
	localparam int HOLD_W    = 8;
	localparam int ALPHA_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int GRAV_W    = 16;
	localparam int EPS_W     = 16;
	localparam int GAIN_FRAC = 12;
	localparam int PROD_W    = LVL_W + ALPHA_W;
	localparam int POS_W     = VEL_W + 2;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = LVL_W;

	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_ALPHA,
		REG_FALL_ALPHA,
		REG_LAUNCH_BASE,
		REG_LAUNCH_GAIN,
		REG_LAUNCH_MAX,
		REG_GRAVITY_STEP,
		REG_APEX_HOLD,
		REG_VISIBLE_EPS
	} cfg_reg_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] rise_alpha;
		logic [ALPHA_W-1:0] fall_alpha;
		logic [LVL_W-1:0]   launch_base;
		logic [GAIN_W-1:0]  launch_gain;
		logic [LVL_W-1:0]   launch_max;
		logic [GRAV_W-1:0]  gravity_step;
		logic [HOLD_W-1:0]  apex_hold_frames;
		logic [EPS_W-1:0]   visible_epsilon;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rise_alpha:       16'd32768,
		fall_alpha:       16'd8192,
		launch_base:      18'd1000,
		launch_gain:      16'd4096,
		launch_max:       18'd8000,
		gravity_step:     16'd400,
		apex_hold_frames: 8'd3,
		visible_epsilon:  16'd64
	};

	typedef enum logic [1:0] {
		KIND_FRAME,
		KIND_RESTART,
		KIND_SKIP
	} kind_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [LVL_W-1:0] level;
		kind_t            kind;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0]        bar;
		logic [LVL_W-1:0]        cap;
		logic signed [VEL_W-1:0] vel;
		logic [HOLD_W-1:0]       hold;
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/peak_meter_ballistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peak_meter_ballistics
// per-column peak meter: eased bar plus a ballistic cap with apex hold
// ----------------------------------------------------------------------------
// usage
//   input words (column, level, restart) enter on in_valid / in_stall, one
//   word per column per frame; every word gives exactly one result word on
//   out_valid / out_stall, in input order; registers are written on
//   cfg_valid / cfg_ready (ready is always high), by the user only while the
//   meter is idle, unchecked by the block; unknown indexes are dropped
// throughput
//   each word passes through the queue, the update stage and output register;
//   one word per cycle sustained while out_stall stays low, including the
//   same column back to back, as the column update reads the state memory
//   with the just-written state forwarded around it
// structure
//   front sorts each word (frame, restart, out of range) into a two-word
//   queue; the back reads the column state, updates it and writes it back
// reset
//   all columns read as zero at once through per-column valid bits, so there
//   is no clearing pass; registers return to their defaults
// stall
//   a stalled result holds in the output register; the back stage and the
//   queue fill behind it, then in_stall rises
// ----------------------------------------------------------------------------
module peak_meter_ballistics #(
	parameter int COLUMNS     = pmb_pkg::COLUMNS_DEF,
	parameter int CAP_CEILING = pmb_pkg::CAP_CEILING_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmb_pkg::CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pmb_pkg::COL_W-1:0]      column,
	input  logic [pmb_pkg::LVL_W-1:0]      level,
	input  logic                           restart,
	// result words
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pmb_pkg::COL_W-1:0]      out_column,
	output logic [pmb_pkg::LVL_W-1:0]      bar_level,
	output logic [pmb_pkg::LVL_W-1:0]      cap_level,
	output logic                           moving
);
	import pmb_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	item_t q_in_item;
	logic  q_valid;
	logic  q_pop;
	item_t q_head;

	// register file, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RISE_ALPHA:   cfg_q.rise_alpha       <= cfg_data[ALPHA_W-1:0];
				REG_FALL_ALPHA:   cfg_q.fall_alpha       <= cfg_data[ALPHA_W-1:0];
				REG_LAUNCH_BASE:  cfg_q.launch_base      <= cfg_data[LVL_W-1:0];
				REG_LAUNCH_GAIN:  cfg_q.launch_gain      <= cfg_data[GAIN_W-1:0];
				REG_LAUNCH_MAX:   cfg_q.launch_max       <= cfg_data[LVL_W-1:0];
				REG_GRAVITY_STEP: cfg_q.gravity_step     <= cfg_data[GRAV_W-1:0];
				REG_APEX_HOLD:    cfg_q.apex_hold_frames <= cfg_data[HOLD_W-1:0];
				REG_VISIBLE_EPS:  cfg_q.visible_epsilon  <= cfg_data[EPS_W-1:0];
				default: begin
					// index beyond the list: word dropped
				end
			endcase
		end
	end

	// front: accept and classify
	pmb_front #(
		.COLUMNS (COLUMNS)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.column   (column),
		.level    (level),
		.restart  (restart),
		.q_full   (q_full),
		.push     (q_push),
		.item     (q_in_item)
	);

	// queue decouples the input from the state update
	pmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// back: column state read, update, write back and result register
	pmb_back #(
		.COLUMNS     (COLUMNS),
		.CAP_CEILING (CAP_CEILING)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_column (out_column),
		.bar_level  (bar_level),
		.cap_level  (cap_level),
		.moving     (moving)
	);

endmodule
`default_nettype wire

// ===== hdl/pmb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmb_front
// input side: takes level words and sorts them into frame, restart or skip
// ----------------------------------------------------------------------------
module pmb_front #(
	parameter int COLUMNS = pmb_pkg::COLUMNS_DEF
) (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pmb_pkg::COL_W-1:0]  column,
	input  logic [pmb_pkg::LVL_W-1:0]  level,
	input  logic                       restart,
	input  logic                       q_full,
	output logic                       push,
	output pmb_pkg::item_t             item
);
	import pmb_pkg::*;

	localparam logic [8:0] COLS_LIM = 9'(COLUMNS);

	logic in_range;

	assign in_range = {4'b0, column} < COLS_LIM;
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		item.column = column;
		item.level  = level;
		if (!in_range) begin
			item.kind = KIND_SKIP;
		end else if (restart) begin
			item.kind = KIND_RESTART;
		end else begin
			item.kind = KIND_FRAME;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pmb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmb_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module pmb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pmb_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output pmb_pkg::item_t head
);
	import pmb_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	item_t            entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_FULL;
	assign valid = count_q != '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pmb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmb_back
// column state memory, per-frame bar and cap update, result register
// ----------------------------------------------------------------------------
module pmb_back #(
	parameter int COLUMNS     = pmb_pkg::COLUMNS_DEF,
	parameter int CAP_CEILING = pmb_pkg::CAP_CEILING_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pmb_pkg::cfg_t             cfg,
	input  logic                      q_valid,
	input  pmb_pkg::item_t            q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [pmb_pkg::COL_W-1:0] out_column,
	output logic [pmb_pkg::LVL_W-1:0] bar_level,
	output logic [pmb_pkg::LVL_W-1:0] cap_level,
	output logic                      moving
);
	import pmb_pkg::*;

	localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam logic signed [POS_W-1:0] CEIL_S = POS_W'(CAP_CEILING);

	// state memory, with per-column valid bits standing in for the zero reset
	state_t           mem [COLUMNS];
	logic [COLUMNS-1:0] vld_q;

	item_t  item_s1;
	state_t st_s1;
	logic   valid_s1;

	logic                out_valid_q;
	logic [COL_W-1:0]    out_column_q;
	logic [LVL_W-1:0]    bar_level_q;
	logic [LVL_W-1:0]    cap_level_q;
	logic                moving_q;

	logic [IDX_W-1:0] head_addr;
	logic [IDX_W-1:0] addr_s1;
	logic             head_live;
	logic             s1_fire;
	logic             s1_load;
	logic             wr_en;
	logic             fwd_hit;

	// datapath
	logic [LVL_W-1:0]        lvl;
	logic [LVL_W-1:0]        bar0;
	logic [LVL_W-1:0]        cap0;
	logic signed [VEL_W-1:0] vel0;
	logic [HOLD_W-1:0]       hold0;
	logic [LVL_W:0]          eps_x;
	logic [LVL_W:0]          bar0_eps;
	logic [LVL_W:0]          bar1_eps;
	logic [LVL_W:0]          barf_eps;
	logic                    launch;
	logic [LVL_W-1:0]        rise_d;
	logic [PROD_W-1:0]       gain_prod;
	logic [PROD_W-GAIN_FRAC:0] launch_sum;
	logic [LVL_W-1:0]        launch_v;
	logic                    ease_up;
	logic [LVL_W-1:0]        ease_d;
	logic [ALPHA_W-1:0]      alpha;
	logic [PROD_W-1:0]       ease_prod;
	logic [PROD_W-1:0]       ease_rnd;
	logic [LVL_W-1:0]        ease_step;
	logic [LVL_W-1:0]        bar1;
	logic [LVL_W-1:0]        cap1;
	logic signed [VEL_W-1:0] vel1;
	logic [HOLD_W-1:0]       hold1;
	logic [HOLD_W-1:0]       hold_dec;
	logic                    frozen;
	logic signed [POS_W-1:0] pos;
	logic signed [POS_W-1:0] pos_c;
	logic signed [POS_W-1:0] bar1_s;
	logic signed [POS_W-1:0] bar1_eps_s;
	logic signed [VEL_W:0]   nv_raw;
	logic signed [VEL_W-1:0] nv;
	logic                    apex;
	logic                    land;
	state_t                  frame_st;
	state_t                  nx_state;
	logic [LVL_W-1:0]        diff;
	logic                    moving_nx;

	assign head_addr = IDX_W'(q_item.column);
	assign addr_s1   = IDX_W'(item_s1.column);
	assign head_live = q_item.kind != KIND_SKIP;
	assign s1_fire   = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_load   = q_valid && (!valid_s1 || s1_fire);
	assign q_pop     = s1_load;
	assign wr_en     = s1_fire && (item_s1.kind != KIND_SKIP);
	assign fwd_hit   = wr_en && (head_addr == addr_s1);

	always_comb begin
		lvl   = item_s1.level;
		bar0  = st_s1.bar;
		cap0  = st_s1.cap;
		vel0  = st_s1.vel;
		hold0 = st_s1.hold;
		eps_x = {{(LVL_W+1-EPS_W){1'b0}}, cfg.visible_epsilon};

		// launch of a landed cap
		bar0_eps   = {1'b0, bar0} + eps_x;
		launch     = (vel0 == '0) && ({1'b0, cap0} <= bar0_eps) && (lvl > cap0);
		rise_d     = lvl - cap0;
		gain_prod  = PROD_W'(cfg.launch_gain) * PROD_W'(rise_d);
		launch_sum = (PROD_W-GAIN_FRAC+1)'(cfg.launch_base)
			+ (PROD_W-GAIN_FRAC+1)'(gain_prod[PROD_W-1:GAIN_FRAC]);
		launch_v   = (launch_sum > (PROD_W-GAIN_FRAC+1)'(cfg.launch_max))
			? cfg.launch_max : launch_sum[LVL_W-1:0];
		cap1  = launch ? lvl : cap0;
		vel1  = launch ? $signed(VEL_W'(launch_v)) : vel0;
		hold1 = launch ? '0 : hold0;

		// bar easing, rounded step never overshoots the level
		ease_up   = lvl > bar0;
		ease_d    = ease_up ? lvl - bar0 : bar0 - lvl;
		alpha     = ease_up ? cfg.rise_alpha : cfg.fall_alpha;
		ease_prod = PROD_W'(ease_d) * PROD_W'(alpha);
		ease_rnd  = ease_prod + PROD_W'(32768);
		ease_step = ease_rnd[LVL_W+15:16];
		bar1      = ease_up ? bar0 + ease_step : bar0 - ease_step;

		// cap motion
		hold_dec = (hold1 != '0) ? hold1 - 1'b1 : '0;
		frozen   = hold_dec != '0;
		pos      = POS_W'(cap1) + {{(POS_W-VEL_W){vel1[VEL_W-1]}}, vel1};
		nv_raw   = {vel1[VEL_W-1], vel1}
			- {{(VEL_W+1-GRAV_W){1'b0}}, cfg.gravity_step};
		nv       = (nv_raw[VEL_W] && !nv_raw[VEL_W-1]) ? VEL_MIN : nv_raw[VEL_W-1:0];
		pos_c    = (pos > CEIL_S) ? CEIL_S : pos;
		bar1_eps   = {1'b0, bar1} + eps_x;
		bar1_s     = POS_W'(bar1);
		bar1_eps_s = POS_W'(bar1_eps);
		apex = !vel1[VEL_W-1] && (vel1 != '0) && (nv[VEL_W-1] || (nv == '0))
			&& (pos_c > bar1_eps_s);
		land = pos_c <= bar1_s;

		frame_st.bar = bar1;
		if (frozen) begin
			frame_st.cap  = cap1;
			frame_st.vel  = vel1;
			frame_st.hold = hold_dec;
		end else if (apex) begin
			frame_st.cap  = pos_c[LVL_W-1:0];
			frame_st.vel  = '0;
			frame_st.hold = cfg.apex_hold_frames;
		end else if (land) begin
			frame_st.cap  = bar1;
			frame_st.vel  = '0;
			frame_st.hold = '0;
		end else begin
			frame_st.cap  = pos_c[LVL_W-1:0];
			frame_st.vel  = nv;
			frame_st.hold = hold_dec;
		end

		case (item_s1.kind)
			KIND_FRAME: begin
				nx_state = frame_st;
			end
			KIND_RESTART: begin
				nx_state.bar  = lvl;
				nx_state.cap  = lvl;
				nx_state.vel  = '0;
				nx_state.hold = '0;
			end
			default: begin
				nx_state = st_s1;
			end
		endcase

		diff      = (nx_state.bar > lvl) ? nx_state.bar - lvl : lvl - nx_state.bar;
		barf_eps  = {1'b0, nx_state.bar} + eps_x;
		moving_nx = ({1'b0, diff} > eps_x) || (nx_state.vel != '0)
			|| ({1'b0, nx_state.cap} > barf_eps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= nx_state;
		end
		if (s1_load) begin
			item_s1 <= q_item;
			// same column just updated: take the fresh state, not the stale read
			if (fwd_hit) begin
				st_s1 <= nx_state;
			end else if (head_live && vld_q[head_addr]) begin
				st_s1 <= mem[head_addr];
			end else begin
				st_s1 <= '0;
			end
		end
		if (s1_fire) begin
			out_column_q <= item_s1.column;
			if (item_s1.kind == KIND_SKIP) begin
				bar_level_q <= '0;
				cap_level_q <= '0;
				moving_q    <= 1'b0;
			end else begin
				bar_level_q <= nx_state.bar;
				cap_level_q <= nx_state.cap;
				moving_q    <= moving_nx;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_column = out_column_q;
	assign bar_level  = bar_level_q;
	assign cap_level  = cap_level_q;
	assign moving     = moving_q;

`ifndef SYNTHESIS
	// a forwarded load must see exactly the state written alongside it
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_load && fwd_hit) |=> (st_s1 == $past(nx_state)))
		else $error("forwarded column state mismatch");

	// easing keeps the bar between its old position and the level
	a_bar_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.kind == KIND_FRAME) |->
		((frame_st.bar >= bar0 && frame_st.bar <= lvl) ||
		 (frame_st.bar <= bar0 && frame_st.bar >= lvl)))
		else $error("bar passed the level");

	// skipped columns never touch the state memory
	a_skip_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.kind == KIND_SKIP) |-> !wr_en)
		else $error("write for an out of range column");

	// a skipped column reports zeros
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && item_s1.kind == KIND_SKIP) |=>
		(out_valid_q && bar_level_q == '0 && cap_level_q == '0 && !moving_q))
		else $error("nonzero result for skipped column");

	// a cap in flight stays at or below the ceiling
	a_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.kind == KIND_FRAME && !frozen && !land) |->
		(pos_c <= CEIL_S))
		else $error("cap above ceiling");
`endif

endmodule
`default_nettype wire

// ===== test/pmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmb_checker
// follows the register writes and input words of the peak meter, works out
// each column's bar, cap and motion flag, and compares the result words
// ----------------------------------------------------------------------------
module pmb_checker #(
	parameter int COLUMNS     = pmb_pkg::COLUMNS_DEF,
	parameter int CAP_CEILING = pmb_pkg::CAP_CEILING_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [pmb_pkg::COL_W-1:0]      column,
	input  logic [pmb_pkg::LVL_W-1:0]      level,
	input  logic                           restart,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [pmb_pkg::COL_W-1:0]      out_column,
	input  logic [pmb_pkg::LVL_W-1:0]      bar_level,
	input  logic [pmb_pkg::LVL_W-1:0]      cap_level,
	input  logic                           moving,
	output int                             mismatches,
	output int                             outstanding,
	output int                             checked
);
	import pmb_pkg::*;

	localparam longint VEL_FLOOR = -(longint'(1) << (VEL_W - 1));

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [LVL_W-1:0] bar;
		logic [LVL_W-1:0] cap;
		logic             moving;
	} reading_t;

	cfg_t     meter_cfg;
	state_t   col_state [COLUMNS];
	reading_t expected_readings [$];
	reading_t want;
	int       err_count;
	int       seen;

	// one frame of one column: launch, bar easing, then cap flight
	function automatic reading_t advance_column(input logic [COL_W-1:0] col,
			input logic [LVL_W-1:0] lvl, input logic rs);
		reading_t r;
		state_t   s;
		longint   lvl_l, bar_l, cap_l, vel_l, hold_l, eps;
		longint   v, prev, pos, nv, diff;
		bit       frozen;
		r.column = col;
		r.bar    = '0;
		r.cap    = '0;
		r.moving = 1'b0;
		if (col >= COLUMNS)
			return r;
		s      = col_state[col];
		lvl_l  = longint'(lvl);
		bar_l  = longint'(s.bar);
		cap_l  = longint'(s.cap);
		vel_l  = longint'(s.vel);
		hold_l = longint'(s.hold);
		eps    = longint'(meter_cfg.visible_epsilon);
		if (rs) begin
			bar_l  = lvl_l;
			cap_l  = lvl_l;
			vel_l  = 0;
			hold_l = 0;
		end else begin
			if (vel_l == 0 && cap_l <= bar_l + eps && lvl_l > cap_l) begin
				v = longint'(meter_cfg.launch_gain) * (lvl_l - cap_l);
				v = longint'(meter_cfg.launch_base) + (v >>> GAIN_FRAC);
				if (v > longint'(meter_cfg.launch_max))
					v = longint'(meter_cfg.launch_max);
				cap_l  = lvl_l;
				vel_l  = v;
				hold_l = 0;
			end
			if (lvl_l > bar_l)
				bar_l += ((lvl_l - bar_l) * longint'(meter_cfg.rise_alpha) + 32768) >>> 16;
			else if (lvl_l < bar_l)
				bar_l -= ((bar_l - lvl_l) * longint'(meter_cfg.fall_alpha) + 32768) >>> 16;
			frozen = 1'b0;
			if (hold_l > 0) begin
				hold_l--;
				frozen = (hold_l > 0);
			end
			if (!frozen) begin
				prev = vel_l;
				pos  = cap_l + prev;
				nv   = prev - longint'(meter_cfg.gravity_step);
				if (nv < VEL_FLOOR)
					nv = VEL_FLOOR;
				vel_l = nv;
				if (pos > longint'(CAP_CEILING))
					pos = longint'(CAP_CEILING);
				if (prev > 0 && nv <= 0 && pos > bar_l + eps) begin
					cap_l  = pos;
					vel_l  = 0;
					hold_l = longint'(meter_cfg.apex_hold_frames);
				end else if (pos <= bar_l) begin
					cap_l  = bar_l;
					vel_l  = 0;
					hold_l = 0;
				end else begin
					cap_l = pos;
				end
			end
		end
		s.bar  = bar_l[LVL_W-1:0];
		s.cap  = cap_l[LVL_W-1:0];
		s.vel  = vel_l[VEL_W-1:0];
		s.hold = hold_l[HOLD_W-1:0];
		col_state[col] = s;
		diff     = (bar_l > lvl_l) ? bar_l - lvl_l : lvl_l - bar_l;
		r.bar    = s.bar;
		r.cap    = s.cap;
		r.moving = (diff > eps) || (vel_l != 0) || (cap_l > bar_l + eps);
		return r;
	endfunction

	task automatic compare_field(input string what, input logic [LVL_W-1:0] exp_v,
			input logic [LVL_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v,
				got_v);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_cfg = CFG_RESET;
			foreach (col_state[i])
				col_state[i] = '0;
			expected_readings.delete();
			err_count = 0;
			seen      = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RISE_ALPHA:   meter_cfg.rise_alpha       = cfg_data[ALPHA_W-1:0];
					REG_FALL_ALPHA:   meter_cfg.fall_alpha       = cfg_data[ALPHA_W-1:0];
					REG_LAUNCH_BASE:  meter_cfg.launch_base      = cfg_data[LVL_W-1:0];
					REG_LAUNCH_GAIN:  meter_cfg.launch_gain      = cfg_data[GAIN_W-1:0];
					REG_LAUNCH_MAX:   meter_cfg.launch_max       = cfg_data[LVL_W-1:0];
					REG_GRAVITY_STEP: meter_cfg.gravity_step     = cfg_data[GRAV_W-1:0];
					REG_APEX_HOLD:    meter_cfg.apex_hold_frames = cfg_data[HOLD_W-1:0];
					REG_VISIBLE_EPS:  meter_cfg.visible_epsilon  = cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
			// push before pop so a result appearing in the same cycle as its input would still line up
			if (in_valid && !in_stall)
				expected_readings.push_back(advance_column(column, level, restart));
			if (out_valid && !out_stall) begin
				seen++;
				if (expected_readings.size() == 0) begin
					$display("%0t ns: result word for column %0d with nothing expected",
						$time, out_column);
					err_count++;
				end else begin
					want = expected_readings.pop_front();
					compare_field("out_column", LVL_W'(want.column), LVL_W'(out_column));
					compare_field("bar_level", want.bar, bar_level);
					compare_field("cap_level", want.cap, cap_level);
					compare_field("moving", LVL_W'(want.moving), LVL_W'(moving));
				end
			end
		end
		mismatches  <= err_count;
		outstanding <= expected_readings.size();
		checked     <= seen;
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the peak meter with level words and register settings under random
// idling on both sides; the checker beside the block predicts every result
// ----------------------------------------------------------------------------
module testbench;
	import pmb_pkg::*;

	localparam int PHASES          = 7;
	localparam int WORDS_PER_PHASE = 160;
	localparam int DRAIN_CYCLES    = 16;
	localparam int GAP_MAX         = 13;
	localparam int STRAY_BASE      = int'(REG_VISIBLE_EPS) + 1;
	localparam int FULL_SCALE      = 65536;
	localparam int LEVEL_TOP       = (1 << LVL_W) - 1;
	localparam int CFG_BITS        = $bits(cfg_t);

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [COL_W-1:0]      column     = '0;
	logic [LVL_W-1:0]      level      = '0;
	logic                  restart    = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [COL_W-1:0]      out_column;
	logic [LVL_W-1:0]      bar_level;
	logic [LVL_W-1:0]      cap_level;
	logic                  moving;

	int mismatches;
	int outstanding;
	int checked;
	int words_sent = 0;
	int in_brisk   = 0;   // words left in a run with no sender gaps
	int out_brisk  = 0;   // results left in a run with no receiver stalls

	// per-column loudness that the random words follow, like a music signal
	logic [LVL_W-1:0] envelope [COLUMNS_DEF] = '{default: '0};

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	peak_meter_ballistics u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.column     (column),
		.level      (level),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_column (out_column),
		.bar_level  (bar_level),
		.cap_level  (cap_level),
		.moving     (moving)
	);

	pmb_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.column      (column),
		.level       (level),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_column  (out_column),
		.bar_level   (bar_level),
		.cap_level   (cap_level),
		.moving      (moving),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// one input word: optional gap, then hold valid until the block takes it;
	// returns on the accepting edge with valid still high, so a following
	// word with no gap goes out back to back
	task automatic send_word(input logic [COL_W-1:0] col, input logic [LVL_W-1:0] lvl,
			input logic rs);
		int gap;
		if (in_brisk > 0) begin
			gap = 0;
			in_brisk--;
		end else if ($urandom_range(0, 39) == 0) begin
			gap      = 0;
			in_brisk = 30;
		end else begin
			gap = $urandom_range(0, GAP_MAX);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		column   <= col;
		level    <= lvl;
		restart  <= rs;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// register write; valid stays high across a batch of writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val, input int bits);
		logic [CFG_DATA_W-1:0] keep;
		keep      = (CFG_DATA_W'(1) << bits) - 1'b1;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		// unused upper bits carry noise, the block must drop them
		cfg_data  <= (CFG_DATA_W'($urandom) & ~keep) | (val & keep);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input cfg_t s);
		write_reg(REG_RISE_ALPHA, CFG_DATA_W'(s.rise_alpha), ALPHA_W);
		write_reg(REG_FALL_ALPHA, CFG_DATA_W'(s.fall_alpha), ALPHA_W);
		write_reg(REG_LAUNCH_BASE, s.launch_base, LVL_W);
		write_reg(REG_LAUNCH_GAIN, CFG_DATA_W'(s.launch_gain), GAIN_W);
		// an index past the register list, to be ignored
		write_reg(CFG_IDX_W'(STRAY_BASE + $urandom_range(0, 7)), CFG_DATA_W'($urandom),
			CFG_DATA_W);
		write_reg(REG_LAUNCH_MAX, s.launch_max, LVL_W);
		write_reg(REG_GRAVITY_STEP, CFG_DATA_W'(s.gravity_step), GRAV_W);
		write_reg(REG_APEX_HOLD, CFG_DATA_W'(s.apex_hold_frames), HOLD_W);
		write_reg(REG_VISIBLE_EPS, CFG_DATA_W'(s.visible_epsilon), EPS_W);
		cfg_valid <= 1'b0;
	endtask

	// settings per phase: all zero, all ones, wide random, and lively ones
	// where caps fly, pause and land within a few dozen frames
	function automatic cfg_t pick_settings(input int phase);
		cfg_t s;
		case (phase)
			1: s = '0;
			2: s = '1;
			3, 6: s = CFG_BITS'({$urandom, $urandom, $urandom, $urandom});
			default: begin
				s                  = CFG_RESET;
				s.rise_alpha       = ALPHA_W'($urandom);
				s.fall_alpha       = ALPHA_W'($urandom_range(256, 32768));
				s.launch_base      = LVL_W'($urandom_range(0, 4000));
				s.launch_gain      = GAIN_W'($urandom_range(0, 16384));
				s.launch_max       = LVL_W'($urandom_range(1000, 30000));
				s.gravity_step     = GRAV_W'($urandom_range(100, 3000));
				s.apex_hold_frames = HOLD_W'($urandom_range(0, 6));
				s.visible_epsilon  = EPS_W'($urandom_range(0, 300));
			end
		endcase
		return s;
	endfunction

	// mostly hits and decays on a few columns at a time so each column sees
	// long runs of frames; some raw noise and the odd restart mixed in
	task automatic random_words(input int count);
		logic [COL_W-1:0] pick [4];
		logic [COL_W-1:0] col;
		logic [LVL_W-1:0] lvl;
		int               roll;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				foreach (pick[k])
					pick[k] = COL_W'($urandom_range(0, COLUMNS_DEF - 1));
			col  = pick[$urandom_range(0, 3)];
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				lvl = LVL_W'($urandom);
			end else begin
				if (roll < 22)
					envelope[col] = LVL_W'(($urandom_range(0, 99) < 85)
						? $urandom_range(0, FULL_SCALE)
						: $urandom_range(FULL_SCALE + 1, LEVEL_TOP));
				else if (roll < 40)
					envelope[col] = envelope[col];
				else
					envelope[col] = envelope[col] - (envelope[col] >> 3);
				lvl = envelope[col];
			end
			send_word(col, lvl, $urandom_range(0, 99) < 3);
		end
	endtask

	// drop valid and wait until every result word has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// receiver: random stall before each result, with stall-free runs
	initial begin : result_sink
		int n;
		@(posedge clk);
		forever begin
			if (out_brisk > 0) begin
				n = 0;
				out_brisk--;
			end else if ($urandom_range(0, 39) == 0) begin
				n         = 0;
				out_brisk = 40;
			end else begin
				n = $urandom_range(0, GAP_MAX);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: quiet column, full-scale hit and launch, fall back
		send_word(5'd0, 18'd0, 1'b0);
		send_word(5'd0, LVL_W'(FULL_SCALE), 1'b0);
		send_word(5'd0, LVL_W'(FULL_SCALE), 1'b0);
		send_word(5'd0, 18'd0, 1'b0);
		send_word(5'd0, 18'd0, 1'b0);
		// top column restarted at the top level, then held and dropped
		send_word(5'd31, LVL_W'(LEVEL_TOP), 1'b1);
		send_word(5'd31, LVL_W'(LEVEL_TOP), 1'b0);
		send_word(5'd31, 18'd0, 1'b0);
		send_word(5'd31, 18'd0, 1'b0);
		// launch far above the ceiling, cap clamped while the bar chases
		send_word(5'd1, LVL_W'(LEVEL_TOP), 1'b0);
		send_word(5'd1, LVL_W'(LEVEL_TOP), 1'b0);
		send_word(5'd1, 18'd0, 1'b0);
		// alternating bit patterns on the level, easing both ways
		send_word(5'd2, 18'h2AAAA, 1'b1);
		send_word(5'd2, 18'h15555, 1'b0);
		send_word(5'd2, 18'h2AAAA, 1'b0);
		send_word(5'd21, LVL_W'(2 * FULL_SCALE), 1'b0);
		// levels right at the visibility tolerance
		send_word(5'd10, 18'd65, 1'b0);
		send_word(5'd10, 18'd64, 1'b0);
		send_word(5'd10, 18'd0, 1'b1);
		send_word(5'd10, 18'd1, 1'b0);
		send_word(5'd0, 18'd0, 1'b1);
		random_words(WORDS_PER_PHASE);

		for (int p = 1; p < PHASES; p++) begin
			settle();
			load_settings(pick_settings(p));
			random_words(WORDS_PER_PHASE);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d level words over %0d register settings, %0d results checked",
			words_sent, PHASES, checked);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d results still awaited", outstanding);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
